[rtl/core/plro_pkg.sv]
// Shared types and constants for the planar raster-op unit.
// No dependencies; imported by every module of the block except the port checker.
package plro_pkg;

  localparam int NumPlanes = 4;
  localparam int PlaneCntW = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int AddrW     = 17;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_COMMAND       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOGIC_COLOR   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PLANE_DISABLE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TILE_PATTERN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COMPARE_COLS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HIDDEN_PLANES = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PLANE_COUNT   = 3'd6;

  // Operation codes, command bits 2:0
  localparam logic [2:0] OP_PSET    = 3'd0;
  localparam logic [2:0] OP_BLANK   = 3'd1;
  localparam logic [2:0] OP_OR      = 3'd2;
  localparam logic [2:0] OP_AND     = 3'd3;
  localparam logic [2:0] OP_XOR     = 3'd4;
  localparam logic [2:0] OP_NOT     = 3'd5;
  localparam logic [2:0] OP_TILE    = 3'd6;
  localparam logic [2:0] OP_COMPARE = 3'd7;

  localparam int CmdNandBit = 5;
  localparam int CmdCmpBit  = 6;
  localparam int EntSkipBit = 7;

  localparam logic [AddrW-1:0]     HighAddr       = 17'h08000;
  localparam logic [PlaneCntW-1:0] PlaneCountRst  = 3'd3;

  typedef logic [NumPlanes-1:0][7:0] plane_vec_t;

  typedef struct packed {
    logic [7:0]           command;
    logic [3:0]           logic_color;
    logic [3:0]           plane_disable;
    logic [3:0][7:0]      tile_pattern;
    logic [7:0][7:0]      compare_colors;
    logic [3:0]           hidden_planes;
    logic [PlaneCntW-1:0] plane_count;
  } cfg_t;

endpackage

[rtl/core/plro_cfg_regs.sv]
// Configuration register file of the planar raster-op unit.
// Depends on plro_pkg for register indexes and the cfg_t bundle.
module plro_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [plro_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [plro_pkg::CfgDataW-1:0] wr_data,
  output plro_pkg::cfg_t                cfg
);
  import plro_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the index and update the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_COMMAND:       cfg_nxt.command        = wr_data[7:0];
        REG_LOGIC_COLOR:   cfg_nxt.logic_color    = wr_data[3:0];
        REG_PLANE_DISABLE: cfg_nxt.plane_disable  = wr_data[3:0];
        REG_TILE_PATTERN:  cfg_nxt.tile_pattern   = wr_data[31:0];
        REG_COMPARE_COLS:  cfg_nxt.compare_colors = wr_data;
        REG_HIDDEN_PLANES: cfg_nxt.hidden_planes  = wr_data[3:0];
        REG_PLANE_COUNT:   cfg_nxt.plane_count    = wr_data[PlaneCntW-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{command: '0, logic_color: '0, plane_disable: '0, tile_pattern: '0,
                 compare_colors: '0, hidden_planes: '0, plane_count: PlaneCountRst};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/plro_compare.sv]
// Colour compare: builds the per-bit match status from the plane bytes.
// Depends on plro_pkg for plane_vec_t and cfg_t.
module plro_compare #(
  parameter int COMPARE_ENTRIES = 8
) (
  input  plro_pkg::plane_vec_t            rd,
  input  plro_pkg::cfg_t                  cfg,
  input  logic [plro_pkg::PlaneCntW-1:0]  plane_cnt,
  output logic [7:0]                      status
);
  import plro_pkg::*;

  logic [3:0] en;
  logic [3:0] col [8];

  // Plane three takes part only when four planes are active
  always_comb begin
    en = ~cfg.plane_disable;
    if (plane_cnt < PlaneCntW'(NumPlanes)) en[3] = 1'b0;
  end

  // Each pixel bit against every non-skipped entry
  always_comb begin
    status = '0;
    for (int b = 0; b < 8; b++) begin
      for (int p = 0; p < NumPlanes; p++) col[b][p] = rd[p][b];
      col[b] = col[b] & en;
      for (int j = 0; j < COMPARE_ENTRIES; j++) begin
        if (!cfg.compare_colors[j][EntSkipBit] &&
            ((cfg.compare_colors[j][3:0] & en) == col[b])) begin
          status[b] = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/plro_merge.sv]
// One plane's logic operation, write-mask merge and compare-steered merge.
// Depends on plro_pkg for operation codes.
module plro_merge (
  input  logic [2:0] op,
  input  logic       color,
  input  logic [7:0] tile,
  input  logic [7:0] rd,
  input  logic [7:0] mask,
  input  logic       cmp_en,
  input  logic       nand_sel,
  input  logic [7:0] status,
  output logic [7:0] dout
);
  import plro_pkg::*;

  logic [7:0] v;
  logic [7:0] d;

  // Source byte for the operation
  always_comb begin
    case (op)
      OP_PSET:  v = color ? 8'hff : 8'h00;
      OP_BLANK: v = 8'h00;
      OP_OR:    v = color ? 8'hff : rd;
      OP_AND:   v = color ? rd : 8'h00;
      OP_XOR:   v = color ? ~rd : rd;
      OP_NOT:   v = ~rd;
      default:  v = tile;
    endcase
  end

  // Protected bits keep the current byte, then let the status steer
  always_comb begin
    d = (rd & mask) | (v & ~mask);
    if (!cmp_en)       dout = d;
    else if (nand_sel) dout = (rd & status) | (d & ~status);
    else               dout = (rd & ~status) | (d & status);
  end

endmodule

[rtl/core/plane_logic_raster_op_unit.sv]
// Top level of the planar raster-op unit: input register, logic, result register.
// Depends on plro_pkg, plro_cfg_regs, plro_compare and plro_merge.
//
//  channel | direction | handshake          | payload
//  in      | to unit   | in_valid/in_ready  | operation, address, mask_value, plane bytes
//  out     | from unit | out_valid/out_ready| write_enable, new plane bytes, compare_result
//  cfg     | to unit   | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One transaction per cycle unless the output stalls; each item is held in the input
// register, then the result register. The path from the input register through compare
// and merge to the result register sets the cycle; write mask and compare status update
// as each item leaves. A stalled output holds the result; the input register still takes
// one more item. Synchronous reset clears valids, write mask and compare status, and
// returns the configuration to its defaults.
module plane_logic_raster_op_unit #(
  parameter int MAX_PLANES      = 4,
  parameter int COMPARE_ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [plro_pkg::AddrW-1:0]    in_address,
  input  logic [7:0]                    in_mask_value,
  input  logic [7:0]                    in_plane_b,
  input  logic [7:0]                    in_plane_r,
  input  logic [7:0]                    in_plane_g,
  input  logic [7:0]                    in_plane_t,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_write_enable,
  output logic [7:0]                    out_new_b,
  output logic [7:0]                    out_new_r,
  output logic [7:0]                    out_new_g,
  output logic [7:0]                    out_new_t,
  output logic [7:0]                    out_compare_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plro_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [plro_pkg::CfgDataW-1:0] cfg_data
);
  import plro_pkg::*;

  localparam logic [PlaneCntW-1:0] MaxPlanesC = PlaneCntW'(MAX_PLANES);

  cfg_t cfg;

  // Input register
  logic             in_valid_r;
  logic             opr_r;
  logic [AddrW-1:0] addr_r;
  logic [7:0]       mval_r;
  plane_vec_t       cur_r;

  // Unit state
  logic [7:0] wmask_r, wmask_nxt;
  logic [7:0] status_r, status_nxt;

  // Result register
  logic       out_valid_r;
  logic [3:0] we_r, we_nxt;
  plane_vec_t nb_r, nb_nxt;
  logic [7:0] cres_r;

  logic                 advance;
  logic                 is_access;
  logic                 do_cmp;
  logic [2:0]           op;
  logic [PlaneCntW-1:0] plane_cnt;
  plane_vec_t           rd;
  plane_vec_t           merged;
  logic [7:0]           cmp_status;

  assign cfg_ready = 1'b1;

  plro_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: move an item on when the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opr_r  <= in_operation;
      addr_r <= in_address;
      mval_r <= in_mask_value;
      cur_r  <= {in_plane_t, in_plane_g, in_plane_r, in_plane_b};
    end
  end

  // Hidden planes read as all ones
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) rd[p] = cfg.hidden_planes[p] ? 8'hff : cur_r[p];
  end

  assign plane_cnt = (cfg.plane_count > MaxPlanesC) ? MaxPlanesC : cfg.plane_count;
  assign op        = cfg.command[2:0];
  assign is_access = !opr_r && (addr_r < HighAddr);
  assign do_cmp    = is_access && ((op == OP_COMPARE) || cfg.command[CmdCmpBit]);

  plro_compare #(
    .COMPARE_ENTRIES (COMPARE_ENTRIES)
  ) u_cmp (
    .rd        (rd),
    .cfg       (cfg),
    .plane_cnt (plane_cnt),
    .status    (cmp_status)
  );

  // Next write mask and compare status
  always_comb begin
    if (opr_r)                  wmask_nxt = mval_r;
    else if (addr_r >= HighAddr) wmask_nxt = 8'hff;
    else                        wmask_nxt = wmask_r;
    status_nxt = do_cmp ? cmp_status : status_r;
  end

  for (genvar g = 0; g < NumPlanes; g++) begin : g_plane
    plro_merge u_merge (
      .op       (op),
      .color    (cfg.logic_color[g]),
      .tile     (cfg.tile_pattern[g]),
      .rd       (rd[g]),
      .mask     (wmask_r),
      .cmp_en   (cfg.command[CmdCmpBit]),
      .nand_sel (cfg.command[CmdNandBit]),
      .status   (status_nxt),
      .dout     (merged[g])
    );
  end

  // Write enables and gated plane bytes
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      we_nxt[p] = is_access && (op != OP_COMPARE) && (PlaneCntW'(p) < plane_cnt) &&
                  !cfg.plane_disable[p] && !cfg.hidden_planes[p];
      nb_nxt[p] = we_nxt[p] ? merged[p] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmask_r     <= '0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        wmask_r  <= wmask_nxt;
        status_r <= status_nxt;
      end
      if (advance)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      we_r   <= we_nxt;
      nb_r   <= nb_nxt;
      cres_r <= status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_enable   = we_r;
  assign out_new_b          = nb_r[0];
  assign out_new_r          = nb_r[1];
  assign out_new_g          = nb_r[2];
  assign out_new_t          = nb_r[3];
  assign out_compare_result = cres_r;

endmodule

[rtl/core/plro_checker.sv]
// Port-level checks for the planar raster-op unit, bound to the top level.
// Depends only on the top level's port names and widths.
module plro_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_write_enable,
  input logic [7:0] out_new_b,
  input logic [7:0] out_new_r,
  input logic [7:0] out_new_g,
  input logic [7:0] out_new_t,
  input logic [7:0] out_compare_result
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A held result keeps its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_enable) &&
    $stable(out_new_b) && $stable(out_new_r) && $stable(out_new_g) &&
    $stable(out_new_t) && $stable(out_compare_result))
    else $error("stalled result changed");

  // Input back-pressure only while the output is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // Planes that are not written carry a zero byte
  a_gated_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_enable[0] || out_new_b == 8'h00) &&
                  (out_write_enable[1] || out_new_r == 8'h00) &&
                  (out_write_enable[2] || out_new_g == 8'h00) &&
                  (out_write_enable[3] || out_new_t == 8'h00))
    else $error("unwritten plane with non-zero byte");

endmodule

bind plane_logic_raster_op_unit plro_checker u_plro_checker (.*);
